// ===== design/udp_socket_demux_table_macros.svh =====
// Assertion macros for the UDP socket demultiplexing table.
`ifndef UDP_SOCKET_DEMUX_TABLE_MACROS_SVH
`define UDP_SOCKET_DEMUX_TABLE_MACROS_SVH

`ifndef SYNTHESIS

`define UDPDT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("udpdt assertion failed");

`define UDPDT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("udpdt assertion failed");

`else

`define UDPDT_ASSERT_SAME(label, ante, cons)

`define UDPDT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/udpdt_pkg.sv =====
// Package with types, codes and defaults of the UDP socket demultiplexing table.
`default_nettype none

package udpdt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int PORT_FIRST_DEF  = 4096;
   localparam int PORT_LAST_DEF   = 32767;

   localparam int ADDR_W      = 32;
   localparam int PORT_W      = 16;
   localparam int SLOT_W      = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [1:0] OP_BIND    = 2'd0;
   localparam logic [1:0] OP_CONNECT = 2'd1;
   localparam logic [1:0] OP_REMOVE  = 2'd2;
   localparam logic [1:0] OP_LOOKUP  = 2'd3;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_ADDR_UNAVAIL = 2'd1;
   localparam logic [1:0] STATUS_NO_SLOT      = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NET_MASK    = 1'd1;

   localparam logic [ADDR_W-1:0] NET_MASK_RESET = 32'hFFFF_FF00;
   localparam logic [3:0]        MCAST_NIBBLE   = 4'hE;

   typedef struct packed {
      logic [1:0]        op;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] ip_a;
      logic [ADDR_W-1:0] ip_b;
      logic [PORT_W-1:0] port_a;
      logic [PORT_W-1:0] port_b;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot_out;
      logic [PORT_W-1:0] local_port_out;
      logic              send_unreachable;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] local_address;
      logic [PORT_W-1:0] bound_port;
      logic [ADDR_W-1:0] remote_address;
      logic [PORT_W-1:0] peer_port;
   } entry_type;

   typedef struct packed {
      logic write_entry;
      logic link;
      logic unlink;
      logic connect;
   } tbl_cmd_type;

   typedef struct packed {
      logic listed;
      logic connected;
      logic taken;
   } tbl_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MODIFY,
      ST_ALLOC,
      ST_COMMIT,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_REPLY
   } state_type;

endpackage

`default_nettype wire

// ===== design/udpdt_table.sv =====
// Slot storage: endpoint memory, list ranks, flags and the port-in-use check.
`default_nettype none

module udpdt_table import udpdt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(TABLE_DEPTH)-1:0] idx,
   input  tbl_cmd_type                    cmd,
   input  entry_type                      wdata,
   input  logic [PORT_W-1:0]              cand,
   output entry_type                      rd_entry,
   output logic [$clog2(TABLE_DEPTH)-1:0] rd_rank,
   output tbl_stat_type                   stat
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   entry_type         mem [TABLE_DEPTH];
   entry_type         rd_entry_ff;
   logic              rd_listed_ff;
   logic              rd_conn_ff;
   logic [IDX_W-1:0]  rd_rank_ff;

   logic [TABLE_DEPTH-1:0] listed_ff, listed_in;
   logic [TABLE_DEPTH-1:0] conn_ff, conn_in;
   logic [IDX_W-1:0]       rank_ff [TABLE_DEPTH];
   logic [IDX_W-1:0]       rank_in [TABLE_DEPTH];
   logic [PORT_W-1:0]      port_ff [TABLE_DEPTH];
   logic [PORT_W-1:0]      port_in [TABLE_DEPTH];
   logic                   taken;

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         mem[idx] <= wdata;
      end
      rd_entry_ff  <= mem[idx];
      rd_listed_ff <= listed_ff[idx];
      rd_conn_ff   <= conn_ff[idx];
      rd_rank_ff   <= rank_ff[idx];
   end

   // A slot that is not listed holds no endpoint, so its fields read as zero.
   assign rd_entry = rd_listed_ff ? rd_entry_ff : '0;
   assign rd_rank  = rd_rank_ff;

   always_comb begin
      listed_in = listed_ff;
      conn_in   = conn_ff;
      rank_in   = rank_ff;
      port_in   = port_ff;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (cmd.link && !rd_listed_ff && listed_ff[i]) begin
            rank_in[i] = rank_ff[i] + IDX_W'(1);
         end
         if (cmd.unlink && rd_listed_ff && listed_ff[i] && (rank_ff[i] > rd_rank_ff)) begin
            rank_in[i] = rank_ff[i] - IDX_W'(1);
         end
      end
      if (cmd.write_entry) begin
         port_in[idx] = wdata.bound_port;
      end
      if (cmd.connect) begin
         conn_in[idx] = 1'b1;
      end
      if (cmd.link) begin
         listed_in[idx] = 1'b1;
         if (!rd_listed_ff) begin
            rank_in[idx] = '0;
         end
      end
      if (cmd.unlink) begin
         listed_in[idx] = 1'b0;
         conn_in[idx]   = 1'b0;
         rank_in[idx]   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listed_ff <= '0;
         conn_ff   <= '0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         listed_ff <= listed_in;
         conn_ff   <= conn_in;
         rank_ff   <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      port_ff <= port_in;
   end

   always_comb begin
      taken = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (listed_ff[i] && (port_ff[i] == cand)) begin
            taken = 1'b1;
         end
      end
   end

   assign stat.listed    = rd_listed_ff;
   assign stat.connected = rd_conn_ff;
   assign stat.taken     = taken;

endmodule

`default_nettype wire

// ===== design/udp_socket_demux_table.sv =====
// Top level of the UDP socket demultiplexing table: sequencer, lookup scan, port drawing.
// One word at a time; busy drops in the cycle of the result strobe, results cannot be stalled.
// Lookup: the scan compares one table entry per cycle through the whole table, then strobes.
// Bind/connect: read, modify, commit; remove or a refused bind: read, modify. A drawn port
// tries at most TABLE_DEPTH + 1 candidates. A slot beyond the table is answered from idle.
// Synchronous reset empties the table at once; there is no clearing pass.
`default_nettype none

module udp_socket_demux_table import udpdt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int PORT_FIRST  = PORT_FIRST_DEF,
   parameter int PORT_LAST   = PORT_LAST_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_word,
   output logic                   rsp_strobe,
   output rsp_type                rsp_word,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "udp_socket_demux_table_macros.svh"

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int TRY_W = $clog2(TABLE_DEPTH + 1);

   state_type         state_ff, state_in;
   req_type           req_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   entry_type         wk_ff, wk_in;
   logic [PORT_W-1:0] last_port_ff, last_port_in;
   logic [TRY_W-1:0]  tries_ff, tries_in;
   logic [ADDR_W-1:0] own_addr_ff, net_mask_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_load;
   logic              rd_live_ff;
   logic [IDX_W-1:0]  rd_idx_ff;

   logic              ex_vld_ff, wd_vld_ff;
   logic [IDX_W-1:0]  ex_idx_ff, wd_idx_ff, ex_rank_ff, wd_rank_ff;
   logic [PORT_W-1:0] ex_port_ff, wd_port_ff;

   tbl_cmd_type       cmd;
   entry_type         rd_entry;
   logic [IDX_W-1:0]  rd_rank;
   tbl_stat_type      stat;

   logic              accept;
   logic              slot_ok;
   logic              bind_refused;
   logic [PORT_W:0]   cand_sum;
   logic [PORT_W-1:0] cand;
   logic              alloc_done;
   logic              base_fit, hit_exact, hit_wild, take_exact, take_wild;
   logic [ADDR_W-1:0] host_bits;
   logic              bcast, mcast;

   udpdt_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .idx     (idx_ff),
      .cmd     (cmd),
      .wdata   (wk_ff),
      .cand    (cand),
      .rd_entry(rd_entry),
      .rd_rank (rd_rank),
      .stat    (stat)
   );

   assign accept       = start && !busy;
   assign busy         = (state_ff != ST_IDLE);
   assign slot_ok      = (32'(req_word.slot) < 32'(TABLE_DEPTH));
   assign bind_refused = (req_ff.ip_a != '0) && (req_ff.ip_a != own_addr_ff);

   assign cand_sum   = {1'b0, last_port_ff} + (PORT_W + 1)'(1);
   assign cand       = ((cand_sum > (PORT_W + 1)'(PORT_LAST)) ||
                        (cand_sum < (PORT_W + 1)'(PORT_FIRST))) ?
                       PORT_W'(PORT_FIRST) : cand_sum[PORT_W-1:0];
   assign alloc_done = !stat.taken || (tries_ff == TRY_W'(TABLE_DEPTH));

   assign base_fit  = stat.listed && (rd_entry.bound_port == req_ff.port_b) &&
                      ((rd_entry.remote_address == '0) ||
                       (rd_entry.remote_address == req_ff.ip_a)) &&
                      ((rd_entry.local_address == '0) ||
                       (rd_entry.local_address == req_ff.ip_b));
   assign hit_exact  = base_fit && (rd_entry.peer_port == req_ff.port_a);
   assign hit_wild   = base_fit && !stat.connected;
   assign take_exact = rd_live_ff && hit_exact && (!ex_vld_ff || (rd_rank < ex_rank_ff));
   assign take_wild  = rd_live_ff && hit_wild && (!wd_vld_ff || (rd_rank < wd_rank_ff));

   assign host_bits = ~net_mask_ff;
   assign bcast     = ((req_ff.ip_b & host_bits) == host_bits) ||
                      (req_ff.ip_b == '1) || (req_ff.ip_b == '0);
   assign mcast     = (req_ff.ip_b[ADDR_W-1 -: 4] == MCAST_NIBBLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.op == OP_LOOKUP) begin
                  state_in = ST_SCAN;
               end else if (slot_ok) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            case (req_ff.op)
               OP_BIND: begin
                  if (bind_refused) begin
                     state_in = ST_IDLE;
                  end else if (req_ff.port_a != '0) begin
                     state_in = ST_COMMIT;
                  end else begin
                     state_in = ST_ALLOC;
                  end
               end
               OP_CONNECT: begin
                  state_in = (rd_entry.bound_port == '0) ? ST_ALLOC : ST_COMMIT;
               end
               OP_REMOVE: begin
                  state_in = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_ALLOC: begin
            if (alloc_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (idx_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_SCAN_LAST;
            end
         end
         ST_SCAN_LAST: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      wk_in        = wk_ff;
      tries_in     = tries_ff;
      last_port_in = last_port_ff;
      cmd          = '0;
      rsp_load     = 1'b0;
      rsp_in       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.op == OP_LOOKUP) begin
                  idx_in = '0;
               end else if (slot_ok) begin
                  idx_in = IDX_W'(req_word.slot);
               end else begin
                  rsp_load        = 1'b1;
                  rsp_in.status   = STATUS_NO_SLOT;
                  rsp_in.slot_out = req_word.slot;
               end
            end
         end
         ST_MODIFY: begin
            wk_in    = rd_entry;
            tries_in = '0;
            case (req_ff.op)
               OP_BIND: begin
                  if (bind_refused) begin
                     rsp_load              = 1'b1;
                     rsp_in.status         = STATUS_ADDR_UNAVAIL;
                     rsp_in.slot_out       = req_ff.slot;
                     rsp_in.local_port_out = rd_entry.bound_port;
                  end else begin
                     wk_in.local_address = req_ff.ip_a;
                     if (req_ff.port_a != '0) begin
                        wk_in.bound_port = req_ff.port_a;
                     end
                  end
               end
               OP_CONNECT: begin
                  wk_in.remote_address = req_ff.ip_a;
                  wk_in.peer_port      = req_ff.port_a;
               end
               OP_REMOVE: begin
                  cmd.unlink      = 1'b1;
                  rsp_load        = 1'b1;
                  rsp_in.status   = STATUS_OK;
                  rsp_in.slot_out = req_ff.slot;
               end
               default: begin
                  wk_in = rd_entry;
               end
            endcase
         end
         ST_ALLOC: begin
            last_port_in = cand;
            tries_in     = tries_ff + TRY_W'(1);
            if (alloc_done) begin
               wk_in.bound_port = cand;
            end
         end
         ST_COMMIT: begin
            cmd.write_entry       = 1'b1;
            cmd.link              = 1'b1;
            cmd.connect           = (req_ff.op == OP_CONNECT);
            rsp_load              = 1'b1;
            rsp_in.status         = STATUS_OK;
            rsp_in.slot_out       = req_ff.slot;
            rsp_in.local_port_out = wk_ff.bound_port;
         end
         ST_SCAN: begin
            if (idx_ff != IDX_W'(TABLE_DEPTH - 1)) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_REPLY: begin
            rsp_load = 1'b1;
            if (ex_vld_ff) begin
               rsp_in.status         = STATUS_OK;
               rsp_in.slot_out       = SLOT_W'(ex_idx_ff);
               rsp_in.local_port_out = ex_port_ff;
            end else if (wd_vld_ff) begin
               rsp_in.status         = STATUS_OK;
               rsp_in.slot_out       = SLOT_W'(wd_idx_ff);
               rsp_in.local_port_out = wd_port_ff;
            end else begin
               rsp_in.status           = STATUS_NO_SLOT;
               rsp_in.send_unreachable = !bcast && !mcast;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         last_port_ff <= PORT_W'(PORT_FIRST);
         tries_ff     <= '0;
         own_addr_ff  <= '0;
         net_mask_ff  <= NET_MASK_RESET;
         rsp_valid_ff <= 1'b0;
         rd_live_ff   <= 1'b0;
         ex_vld_ff    <= 1'b0;
         wd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         last_port_ff <= last_port_in;
         tries_ff     <= tries_in;
         rsp_valid_ff <= rsp_load;
         rd_live_ff   <= (state_ff == ST_SCAN);
         if (csr_we && (csr_index == CSR_OWN_ADDRESS)) begin
            own_addr_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_NET_MASK)) begin
            net_mask_ff <= csr_wdata;
         end
         if (accept) begin
            ex_vld_ff <= 1'b0;
            wd_vld_ff <= 1'b0;
         end else begin
            if (take_exact) begin
               ex_vld_ff <= 1'b1;
            end
            if (take_wild) begin
               wd_vld_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
      wk_ff     <= wk_in;
      rd_idx_ff <= idx_ff;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (take_exact) begin
         ex_idx_ff  <= rd_idx_ff;
         ex_rank_ff <= rd_rank;
         ex_port_ff <= rd_entry.bound_port;
      end
      if (take_wild) begin
         wd_idx_ff  <= rd_idx_ff;
         wd_rank_ff <= rd_rank;
         wd_port_ff <= rd_entry.bound_port;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   `UDPDT_ASSERT_NEXT(a_accept_moves_on, start && !busy, busy || rsp_strobe)
   `UDPDT_ASSERT_SAME(a_result_when_idle, rsp_strobe, !busy)
   `UDPDT_ASSERT_SAME(a_alloc_bounded, state_ff == ST_ALLOC, tries_ff <= TRY_W'(TABLE_DEPTH))
   `UDPDT_ASSERT_NEXT(a_scan_feeds_check, state_ff == ST_SCAN, rd_live_ff)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the UDP socket demultiplexing table: random and directed words vs. a predictor.
`timescale 1ns / 100ps

import udpdt_pkg::*;

class demux_scoreboard;
   logic [31:0] own_addr;
   logic [31:0] net_mask;
   bit          listed [TABLE_DEPTH_DEF];
   bit          connected [TABLE_DEPTH_DEF];
   logic [31:0] local_addr [TABLE_DEPTH_DEF];
   logic [15:0] bound_port [TABLE_DEPTH_DEF];
   logic [31:0] remote_addr [TABLE_DEPTH_DEF];
   logic [15:0] peer_port [TABLE_DEPTH_DEF];
   int unsigned rank [TABLE_DEPTH_DEF];
   int unsigned last_port;
   rsp_type     expected_rsp [$];
   int          errors;

   function void reset_table();
      own_addr = '0;
      net_mask = NET_MASK_RESET;
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
         unlink_slot(i);
      end
      last_port = PORT_FIRST_DEF;
      expected_rsp.delete();
      errors = 0;
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [31:0] data);
      if (index == CSR_OWN_ADDRESS) begin
         own_addr = data;
      end else if (index == CSR_NET_MASK) begin
         net_mask = data;
      end
   endfunction

   function bit port_in_use(int unsigned port);
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
         if (listed[i] && bound_port[i] == port) return 1'b1;
      end
      return 1'b0;
   endfunction

   // The old port of the slot being bound still counts as taken here.
   function logic [15:0] draw_ephemeral();
      int unsigned cand;
      cand = last_port;
      for (int tries = 0; tries <= TABLE_DEPTH_DEF; tries++) begin
         cand++;
         if (cand > PORT_LAST_DEF || cand < PORT_FIRST_DEF) cand = PORT_FIRST_DEF;
         if (!port_in_use(cand)) break;
      end
      last_port = cand;
      return cand[15:0];
   endfunction

   function void link_first(int s);
      if (listed[s]) return;
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
         if (listed[i]) rank[i]++;
      end
      listed[s] = 1'b1;
      rank[s] = 0;
   endfunction

   function void unlink_slot(int s);
      if (listed[s]) begin
         for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            if (listed[i] && rank[i] > rank[s]) rank[i]--;
         end
      end
      listed[s] = 1'b0;
      connected[s] = 1'b0;
      local_addr[s] = '0;
      bound_port[s] = '0;
      remote_addr[s] = '0;
      peer_port[s] = '0;
      rank[s] = 0;
   endfunction

   function int find_slot(bit exact, logic [31:0] src, logic [31:0] dst,
                          logic [15:0] sport, logic [15:0] dport);
      int best;
      best = -1;
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
         if (!listed[i] || bound_port[i] != dport) continue;
         if (remote_addr[i] != 0 && remote_addr[i] != src) continue;
         if (local_addr[i] != 0 && local_addr[i] != dst) continue;
         if (exact ? (peer_port[i] != sport) : connected[i]) continue;
         if (best < 0 || rank[i] < rank[best]) best = i;
      end
      return best;
   endfunction

   function rsp_type table_response(req_type r);
      rsp_type     o;
      int          hit;
      int          s;
      logic [31:0] host;
      bit          bcast;
      o.status = STATUS_OK;
      o.slot_out = r.slot;
      o.local_port_out = '0;
      o.send_unreachable = 1'b0;
      s = r.slot;
      case (r.op)
         OP_LOOKUP: begin
            hit = find_slot(1'b1, r.ip_a, r.ip_b, r.port_a, r.port_b);
            if (hit < 0) hit = find_slot(1'b0, r.ip_a, r.ip_b, r.port_a, r.port_b);
            if (hit >= 0) begin
               o.slot_out = hit[SLOT_W-1:0];
               o.local_port_out = bound_port[hit];
            end else begin
               host = ~net_mask;
               bcast = ((r.ip_b & host) == host) || r.ip_b == 32'hFFFF_FFFF || r.ip_b == 0;
               o.status = STATUS_NO_SLOT;
               o.slot_out = '0;
               o.send_unreachable = !bcast && (r.ip_b[31:28] != MCAST_NIBBLE);
            end
         end
         OP_BIND: begin
            if (r.ip_a != 0 && r.ip_a != own_addr) begin
               o.status = STATUS_ADDR_UNAVAIL;
            end else begin
               local_addr[s] = r.ip_a;
               if (r.port_a != 0) begin
                  bound_port[s] = r.port_a;
               end else begin
                  bound_port[s] = draw_ephemeral();
               end
               link_first(s);
            end
            o.local_port_out = bound_port[s];
         end
         OP_CONNECT: begin
            remote_addr[s] = r.ip_a;
            peer_port[s] = r.port_a;
            connected[s] = 1'b1;
            if (bound_port[s] == 0) bound_port[s] = draw_ephemeral();
            link_first(s);
            o.local_port_out = bound_port[s];
         end
         default: begin
            unlink_slot(s);
         end
      endcase
      return o;
   endfunction

   function void note_request(req_type r);
      expected_rsp.push_back(table_response(r));
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: unexpected word: status %0d slot %0d port %0d unreach %0b",
                     $time, got.status, got.slot_out, got.local_port_out,
                     got.send_unreachable);
         end
         return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status || got.slot_out !== want.slot_out ||
          got.local_port_out !== want.local_port_out ||
          got.send_unreachable !== want.send_unreachable) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: expected status %0d slot %0d port %0d unreach %0b", $time,
                     want.status, want.slot_out, want.local_port_out, want.send_unreachable);
            $display("%0t: got      status %0d slot %0d port %0d unreach %0b", $time,
                     got.status, got.slot_out, got.local_port_out, got.send_unreachable);
         end
      end
   endfunction

   function int pending();
      return expected_rsp.size();
   endfunction

   function int final_errors();
      return errors + expected_rsp.size();
   endfunction
endclass

module tb_top;
   localparam logic [31:0] HOME_ADDR = 32'hC0A8_0105;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   req_type                req_word = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_word;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   demux_scoreboard board;
   int              idle_pct = 0;

   udp_socket_demux_table dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_response(rsp_word);
   end

   task automatic send_word(input req_type w);
      req_word <= w;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      board.note_request(w);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_op(input logic [1:0] op, input int slot, input logic [31:0] src,
                          input logic [31:0] dst, input logic [15:0] sport,
                          input logic [15:0] dport);
      req_type w;
      w.op = op;
      w.slot = SLOT_W'(slot);
      w.ip_a = src;
      w.ip_b = dst;
      w.port_a = sport;
      w.port_b = dport;
      send_word(w);
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (busy || board.pending() != 0);
   endtask

   task automatic program_regs(input logic [31:0] own, input logic [31:0] mask);
      csr_we <= 1'b1;
      csr_index <= CSR_OWN_ADDRESS;
      csr_wdata <= own;
      @(posedge clock);
      board.write_reg(CSR_OWN_ADDRESS, own);
      csr_index <= CSR_NET_MASK;
      csr_wdata <= mask;
      @(posedge clock);
      board.write_reg(CSR_NET_MASK, mask);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(7))
         0: return '0;
         1: return board.own_addr;
         2: return 32'hFFFF_FFFF;
         3: return board.own_addr | ~board.net_mask;
         4: return {MCAST_NIBBLE, 28'($urandom)};
         5, 6: return 32'h0A00_0000 + $urandom_range(1, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_port();
      case ($urandom_range(5))
         0: return '0;
         1: return 16'd53;
         2: return 16'hFFFF;
         3: return 16'(PORT_FIRST_DEF + 1 + $urandom_range(24));
         4: return 16'(board.last_port - $urandom_range(3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] bind_addr();
      int r;
      r = $urandom_range(19);
      if (r < 9) return '0;
      if (r < 17) return board.own_addr;
      return pick_addr();
   endfunction

   // Most lookups are aimed at a listed slot so that both search passes get exercised.
   task automatic random_item();
      req_type w;
      int      pick;
      int      s;
      w.op = OP_LOOKUP;
      w.slot = SLOT_W'($urandom_range(15));
      w.ip_a = $urandom;
      w.ip_b = $urandom;
      w.port_a = 16'($urandom);
      w.port_b = 16'($urandom);
      pick = $urandom_range(99);
      s = w.slot;
      if (pick < 8) begin
         w.op = 2'($urandom_range(3));
      end else if (pick < 33) begin
         w.op = OP_BIND;
         w.ip_a = bind_addr();
         w.port_a = pick_port();
      end else if (pick < 48) begin
         w.op = OP_CONNECT;
         w.ip_a = pick_addr();
         w.port_a = pick_port();
      end else if (pick < 56) begin
         w.op = OP_REMOVE;
      end else if (board.listed[s] && pick < 90) begin
         w.port_b = board.bound_port[s];
         w.ip_b = (board.local_addr[s] != 0) ? board.local_addr[s] : pick_addr();
         if (board.remote_addr[s] != 0) w.ip_a = board.remote_addr[s];
         if (board.connected[s] && $urandom_range(3) != 0) w.port_a = board.peer_port[s];
         case ($urandom_range(9))
            0: w.ip_a = w.ip_a ^ (32'h1 << $urandom_range(31));
            1: w.ip_b = pick_addr();
            2: w.port_b = pick_port();
            default: ;
         endcase
      end else begin
         w.ip_b = pick_addr();
         w.port_b = pick_port();
      end
      send_word(w);
   endtask

   initial begin
      int unsigned base;
      board = new;
      board.reset_table();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      program_regs(HOME_ADDR, NET_MASK_RESET);

      send_op(OP_BIND, 0, HOME_ADDR, 0, 16'd0, 0);
      send_op(OP_BIND, 15, 0, 0, 16'hFFFF, 0);
      send_op(OP_BIND, 3, 32'h0A00_0001, 0, 16'd80, 0);
      send_op(OP_CONNECT, 5, 32'hFFFF_FFFF, 0, 16'd0, 0);
      send_op(OP_CONNECT, 0, 32'h0A00_0002, 0, 16'd1234, 0);
      send_op(OP_LOOKUP, 0, 32'h0A00_0002, HOME_ADDR, 16'd1234, board.bound_port[0]);
      send_op(OP_LOOKUP, 0, 32'h0B00_0000, 32'h0102_0304, 16'd1, 16'hFFFF);
      send_op(OP_LOOKUP, 0, 32'h0A00_0009, 32'hC0A8_0107, 16'd7, 16'd9999);
      send_op(OP_LOOKUP, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd9999);
      send_op(OP_LOOKUP, 0, 32'h0000_0000, 32'h0000_0000, 16'd0, 16'd9999);
      send_op(OP_LOOKUP, 0, 32'h0A00_0001, 32'hE000_0001, 16'd5, 16'd9999);
      send_op(OP_LOOKUP, 0, 32'h0A00_0001, 32'hC0A8_01FF, 16'd5, 16'd9999);
      send_op(OP_LOOKUP, 15, 32'h0A00_0001, 32'hEFFF_FFFF, 16'd5, 16'd0);
      send_op(OP_BIND, 7, 0, 0, 16'hFFFF, 0);
      send_op(OP_LOOKUP, 0, 32'h0B00_0000, 32'h0102_0304, 16'd1, 16'hFFFF);
      send_op(OP_REMOVE, 7, 0, 0, 16'd0, 0);
      send_op(OP_LOOKUP, 0, 32'h0B00_0000, 32'h0102_0304, 16'd1, 16'hFFFF);
      send_op(OP_REMOVE, 9, 0, 0, 16'd0, 0);
      send_op(OP_BIND, 5, HOME_ADDR, 0, 16'd0, 0);
      send_op(OP_LOOKUP, 0, 32'hFFFF_FFFF, HOME_ADDR, 16'd0, board.bound_port[5]);

      // Fill the ports just ahead of the counter so that one draw walks every candidate.
      base = board.last_port;
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
         send_op(OP_BIND, i, 0, 0, 16'(base + 1 + i), 0);
      end
      send_op(OP_BIND, 0, 0, 0, 16'd0, 0);

      idle_pct = 0;
      repeat (150) random_item();
      settle();
      program_regs(32'h0000_0000, 32'h0000_0000);
      idle_pct = 68;
      repeat (150) random_item();
      settle();
      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      idle_pct = 30;
      repeat (150) random_item();
      settle();
      program_regs($urandom, 32'hFFFF_FFFF << $urandom_range(1, 31));

      // Bind both ends of the ephemeral range, then draw a few more ports.
      idle_pct = 0;
      send_op(OP_BIND, 0, 0, 0, 16'(PORT_LAST_DEF), 0);
      send_op(OP_BIND, 1, 0, 0, 16'(PORT_FIRST_DEF), 0);
      repeat (8) send_op(OP_BIND, $urandom_range(2, 15), 0, 0, 16'd0, 0);

      idle_pct = 68;
      repeat (150) random_item();
      settle();
      repeat (40) @(posedge clock);
      if (board.final_errors() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #(60_000_000);
      $display("tb_top NOT OK");
      $finish;
   end
endmodule
